>>> design/unordered_pair_set_unit_defines.svh
// ----------------------------------------------------------------------------
// Unordered pair set assertion macros
// Shared concurrent assertion forms for the pair set checker.
// ----------------------------------------------------------------------------
`ifndef UNORDERED_PAIR_SET_UNIT_DEFINES_SVH
`define UNORDERED_PAIR_SET_UNIT_DEFINES_SVH

// property checked on every clock while out of reset
`define UPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock, reset cycles included
`define UPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/ups_pkg.sv
// ----------------------------------------------------------------------------
// Unordered pair set package
// Sizes, command codes and the result layout of the pair set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ups_pkg;

  // table geometry; the bucket count is a power of two so the hash is a mask
  localparam int BUCKETS     = 16;
  localparam int WAYS        = 4;
  localparam int BUCKET_BITS = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  // identifier field width on the bus and the bits of it that take part
  localparam int ID_FIELD_W = 16;
  localparam int ID_BITS    = 16;

  // pair counter, saturating
  localparam int                COUNT_W   = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // bus widths
  localparam int CMD_W      = 2;
  localparam int IN_DATA_W  = ((2 * ID_FIELD_W + 7) / 8) * 8;
  localparam int RES_W      = COUNT_W + 3;
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  typedef logic [ID_BITS-1:0]     id_t;
  typedef logic [BUCKET_BITS-1:0] bucket_t;
  typedef logic [COUNT_W-1:0]     count_t;

  // command codes; the unused code behaves as a query
  typedef enum logic [CMD_W-1:0] {
    CMD_QUERY = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  // result item, present in the lowest bit
  typedef struct packed {
    count_t pair_count;
    logic   bucket_full;
    logic   added;
    logic   present;
  } res_t;

endpackage

>>> design/unordered_pair_set_unit.sv
// ----------------------------------------------------------------------------
// Unordered pair set unit
// Hashed set of unordered object id pairs with query, add and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions arrive on in_tvalid/in_tready with the command in
//   in_tuser and the two object ids in in_tdata. Each one produces exactly
//   one result transaction on out_tvalid/out_tready carrying present, added,
//   bucket_full and the pair count after the command.
//   A pair hashes to bucket (first_id ^ second_id) masked to the bucket
//   count; both orders of a pair land in the same bucket and match.
//   A transaction accepted on the input channel is captured in the input
//   register, looked up and applied as it moves into the output register,
//   and its result is on the output port from then on.
//   Throughput: one transaction per cycle while the receiver takes results;
//   the bucket read, the compare of all ways and the table write-back
//   happen together from the input register. Clear drops every valid bit at once.
//   Reset (rst_n low, synchronous) empties the set, zeroes the count and
//   drops both pipeline stages; no clearing pass is needed afterwards.
//   When the receiver stalls, the result holds and the input register
//   fills; in_tready then drops until out_tready returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unordered_pair_set_unit
  import ups_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // first_id[15:0], second_id[31:16]
  input  logic [CMD_W-1:0]      in_tuser,   // command[1:0]
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // present[0], added[1], bucket_full[2],
                                            // pair_count[9:3]
);

  // input register
  logic             s1_valid_r;
  logic [CMD_W-1:0] s1_cmd_r;
  id_t              s1_first_r;
  id_t              s1_second_r;

  // table: valid bits in resettable flops, ids without reset
  logic [WAYS-1:0]  slot_valid_r  [BUCKETS];
  id_t              slot_first_r  [BUCKETS][WAYS];
  id_t              slot_second_r [BUCKETS][WAYS];
  count_t           count_r;
  count_t           count_nxt;

  // output register
  logic             out_valid_r;
  res_t             res_r;
  res_t             res_nxt;

  logic             advance;
  logic             do_work;
  bucket_t          bkt;
  logic [WAYS-1:0]  hit;
  logic [WAYS-1:0]  free_sel;
  logic             any_free;
  logic             wr_en;
  logic             clr_en;

  // pipeline moves when the output register is empty or being taken
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign do_work   = s1_valid_r && advance;

  // capture the incoming transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r    <= in_tuser;
      s1_first_r  <= in_tdata[ID_BITS-1:0];
      s1_second_r <= in_tdata[ID_FIELD_W +: ID_BITS];
    end
  end

  // bucket hash and way compare in either order
  assign bkt = bucket_t'(s1_first_r ^ s1_second_r);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit[w] = slot_valid_r[bkt][w] &&
               ((slot_first_r[bkt][w] == s1_first_r  &&
                 slot_second_r[bkt][w] == s1_second_r) ||
                (slot_first_r[bkt][w] == s1_second_r &&
                 slot_second_r[bkt][w] == s1_first_r));
    end
  end

  // first free way of the bucket, lowest index wins
  always_comb begin
    free_sel = '0;
    any_free = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (!slot_valid_r[bkt][w] && !any_free) begin
        free_sel[w] = 1'b1;
        any_free    = 1'b1;
      end
    end
  end

  // command decode and result
  always_comb begin
    res_nxt   = '0;
    wr_en     = 1'b0;
    clr_en    = 1'b0;
    count_nxt = count_r;
    unique case (s1_cmd_r)
      CMD_CLEAR: begin
        clr_en    = do_work;
        count_nxt = '0;
      end
      CMD_ADD: begin
        res_nxt.present = |hit;
        if (!(|hit)) begin
          if (any_free) begin
            wr_en         = do_work;
            res_nxt.added = 1'b1;
            if (count_r != COUNT_MAX) begin
              count_nxt = count_r + count_t'(1);
            end
          end else begin
            res_nxt.bucket_full = 1'b1;
          end
        end
      end
      default: begin
        res_nxt.present = |hit;
      end
    endcase
    res_nxt.pair_count = count_nxt;
  end

  // valid bits and pair count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < BUCKETS; b++) begin
        slot_valid_r[b] <= '0;
      end
      count_r <= '0;
    end else if (clr_en) begin
      for (int b = 0; b < BUCKETS; b++) begin
        slot_valid_r[b] <= '0;
      end
      count_r <= '0;
    end else if (wr_en) begin
      slot_valid_r[bkt] <= slot_valid_r[bkt] | free_sel;
      count_r           <= count_nxt;
    end
  end

  // id storage, one way written per add
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int w = 0; w < WAYS; w++) begin
        if (free_sel[w]) begin
          slot_first_r[bkt][w]  <= s1_first_r;
          slot_second_r[bkt][w] <= s1_second_r;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_work) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, res_r};

endmodule

>>> design/ups_checker.sv
// ----------------------------------------------------------------------------
// Unordered pair set checker
// Port level assertions on the input and result channels of the pair set unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "unordered_pair_set_unit_defines.svh"

module ups_checker
  import ups_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic [CMD_W-1:0]      in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  res_t res;
  logic in_stall;
  logic out_stall;
  logic out_added;
  logic out_full;

  assign res       = res_t'(out_tdata[RES_W-1:0]);
  assign in_stall  = in_tvalid && !in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign out_added = out_tvalid && res.added;
  assign out_full  = out_tvalid && res.bucket_full;

  // a stalled input transaction holds its contents
  `UPS_ASSERT(a_in_hold, in_stall |=> in_tvalid && $stable({in_tuser, in_tdata}), "input changed")

  // a stalled result transaction holds its contents
  `UPS_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_tdata), "result changed")

  // a new pair is never reported as already present
  `UPS_ASSERT(a_added_new, out_added |-> !res.present && !res.bucket_full, "added flag conflict")

  // a refused add only happens for an absent pair
  `UPS_ASSERT(a_full_absent, out_full |-> !res.present, "bucket full on a present pair")

  // reset leaves no result pending
  `UPS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind unordered_pair_set_unit ups_checker u_ups_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
